// ===== rtl/animation_frame_sequencer_assert.svh =====
// Assertion macros for the animation frame sequencer RTL.
// Included by the modules that check their own control logic.
`ifndef ANIMATION_FRAME_SEQUENCER_ASSERT_SVH
`define ANIMATION_FRAME_SEQUENCER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define AFS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define AFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AFS_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define AFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/afs_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, codes and types of the animation frame sequencer.
// No dependencies; used by afs_div and animation_frame_sequencer.
package afs_pkg;

    localparam int TIME_BITS  = 48;
    localparam int FRAME_BITS = 16;
    localparam int KIND_W     = 3;
    localparam int DUR_W      = 16;
    localparam int FCNT_W     = 16;
    localparam int THR_W      = 24;
    localparam int LEFT_W     = 25;
    localparam int LOOP_W     = 32;

    // shared divider: dividend covers leftover and frame + steps, divisor 16 bits
    localparam int DIV_W      = 26;
    localparam int DVS_W      = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int IN_DATA_W  = ((TIME_BITS + FRAME_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_W  = 1 + FRAME_BITS + LOOP_W + 1 + 1;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAUSE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

    localparam logic [DUR_W-1:0]  RST_DURATION  = 16'd100;
    localparam logic [FCNT_W-1:0] RST_COUNT     = 16'd1;
    localparam logic              RST_LOOP_MODE = 1'b1;
    localparam logic [THR_W-1:0]  RST_THRESHOLD = 24'd2000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } afs_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } afs_div_rsp_t;

endpackage

// ===== rtl/animation_frame_sequencer.sv =====
`timescale 1ns / 1ps
// Each accepted event passes through ST_EXEC and ST_DONE before m_tvalid; a tick that
// adds time also passes ST_ACC, and a stepping tick waits in ST_DIV1 for a bit-serial
// division in the shared divider and, in loop mode, in ST_DIV2 for a second one.
// ST_DONE holds the result until the output register is free. One beat at a time:
// the next beat is taken once the result is registered and the state is back in idle.
// Synchronous active-low reset restores 100 ms / 1 frame / loop / 2000 ms and leaves no clip loaded.
// Depends on afs_pkg, afs_div and animation_frame_sequencer_assert.svh.
`include "animation_frame_sequencer_assert.svh"
module animation_frame_sequencer import afs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // now_ms[47:0], start_frame[63:48]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // frame_changed[0], frame_index[16:1], loop_count[48:17], finished[49],
    // paused[50], zero fill[55:51]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_DIV1 = 3'd3;
    localparam logic [2:0] ST_DIV2 = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]            state_reg, state_next;

    logic [DUR_W-1:0]      dur_reg, dur_next;
    logic [FCNT_W-1:0]     fcnt_reg, fcnt_next;
    logic                  loop_reg, loop_next;
    logic [THR_W-1:0]      thr_reg, thr_next;

    logic                  loaded_reg, loaded_next;
    logic                  paused_reg, paused_next;
    logic                  finished_reg, finished_next;
    logic [FRAME_BITS-1:0] cur_frame_reg, cur_frame_next;
    logic [LOOP_W-1:0]     loops_reg, loops_next;
    logic [LEFT_W-1:0]     leftover_reg, leftover_next;
    logic [TIME_BITS-1:0]  last_time_reg, last_time_next;

    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [FRAME_BITS-1:0] start_reg, start_next;
    logic [FRAME_BITS-1:0] prev_frame_reg, prev_frame_next;
    logic [TIME_BITS-1:0]  delta_reg, delta_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [DUR_W-1:0]      dur_eff;
    logic [FCNT_W-1:0]     cnt_eff;
    logic [FCNT_W-1:0]     last_frame;
    logic [FRAME_BITS-1:0] restart_sel;
    logic [FRAME_BITS-1:0] restart_frame;
    logic [THR_W-1:0]      delta_capped;
    logic [LEFT_W:0]       left_sum;
    logic [LEFT_W-1:0]     left_new;
    logic [DIV_W-1:0]      abs_frame;
    logic                  changed;

    afs_div_req_t          div_req;
    afs_div_rsp_t          div_rsp;

    afs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        dur_eff       = (dur_reg == '0) ? DUR_W'(1) : dur_reg;
        cnt_eff       = (fcnt_reg == '0) ? FCNT_W'(1) : fcnt_reg;
        last_frame    = cnt_eff - FCNT_W'(1);
        restart_sel   = (kind_reg == KIND_PLAY) ? '0 : start_reg;
        restart_frame = (restart_sel > last_frame) ? last_frame : restart_sel;
        // a jump past the threshold counts as one frame duration
        delta_capped  = (delta_reg > TIME_BITS'(thr_reg)) ? THR_W'(dur_eff)
                                                          : delta_reg[THR_W-1:0];
        left_sum      = (LEFT_W + 1)'(leftover_reg) + (LEFT_W + 1)'(delta_capped);
        left_new      = left_sum[LEFT_W-1:0];
        abs_frame     = DIV_W'(cur_frame_reg) + div_rsp.quot;
        changed       = (kind_reg == KIND_TICK) && (cur_frame_reg != prev_frame_reg);
    end

    always_comb begin
        state_next      = state_reg;
        dur_next        = dur_reg;
        fcnt_next       = fcnt_reg;
        loop_next       = loop_reg;
        thr_next        = thr_reg;
        loaded_next     = loaded_reg;
        paused_next     = paused_reg;
        finished_next   = finished_reg;
        cur_frame_next  = cur_frame_reg;
        loops_next      = loops_reg;
        leftover_next   = leftover_reg;
        last_time_next  = last_time_reg;
        kind_next       = kind_reg;
        now_next        = now_reg;
        start_next      = start_reg;
        prev_frame_next = prev_frame_reg;
        delta_next      = delta_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        div_req.start    = 1'b0;
        div_req.dividend = (state_reg == ST_DIV1) ? abs_frame : DIV_W'(left_new);
        div_req.divisor  = (state_reg == ST_DIV1) ? DVS_W'(cnt_eff) : DVS_W'(dur_eff);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DURATION:  dur_next  = cfg_data[DUR_W-1:0];
                REG_COUNT:     fcnt_next = cfg_data[FCNT_W-1:0];
                REG_LOOP_MODE: loop_next = cfg_data[0];
                REG_THRESHOLD: thr_next  = cfg_data[THR_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next       = s_tuser;
                    now_next        = s_tdata[TIME_BITS-1:0];
                    start_next      = s_tdata[TIME_BITS +: FRAME_BITS];
                    prev_frame_next = cur_frame_reg;
                    state_next      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                unique case (kind_reg)
                    KIND_TICK: begin
                        if (loaded_reg && !paused_reg && !finished_reg) begin
                            last_time_next = now_reg;
                            if (now_reg > last_time_reg) begin
                                delta_next = now_reg - last_time_reg;
                                state_next = ST_ACC;
                            end
                        end
                    end
                    KIND_PLAY, KIND_RESTART: begin
                        if (kind_reg == KIND_RESTART || !loaded_reg) begin
                            loaded_next    = 1'b1;
                            cur_frame_next = restart_frame;
                            loops_next     = '0;
                            leftover_next  = '0;
                            finished_next  = 1'b0;
                            last_time_next = now_reg;
                        end
                    end
                    KIND_PAUSE: paused_next = 1'b1;
                    KIND_RESUME: begin
                        if (paused_reg) begin
                            paused_next    = 1'b0;
                            last_time_next = now_reg;
                            leftover_next  = '0;
                        end
                    end
                    default: ;
                endcase
            end
            ST_ACC: begin
                if (left_new >= LEFT_W'(dur_eff)) begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV1;
                end else begin
                    leftover_next = left_new;
                    state_next    = ST_DONE;
                end
            end
            ST_DIV1: begin
                if (div_rsp.done) begin
                    leftover_next = LEFT_W'(div_rsp.rem);
                    if (loop_reg) begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV2;
                    end else begin
                        if (abs_frame >= DIV_W'(cnt_eff)) begin
                            cur_frame_next = last_frame;
                            finished_next  = 1'b1;
                        end else begin
                            cur_frame_next = abs_frame[FRAME_BITS-1:0];
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV2: begin
                if (div_rsp.done) begin
                    loops_next     = loops_reg + LOOP_W'(div_rsp.quot);
                    cur_frame_next = div_rsp.rem;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{OUT_PAD_W{1'b0}}, paused_reg, finished_reg,
                                     loops_reg, cur_frame_reg, changed};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            dur_reg       <= RST_DURATION;
            fcnt_reg      <= RST_COUNT;
            loop_reg      <= RST_LOOP_MODE;
            thr_reg       <= RST_THRESHOLD;
            loaded_reg    <= 1'b0;
            paused_reg    <= 1'b0;
            finished_reg  <= 1'b0;
            cur_frame_reg <= '0;
            loops_reg     <= '0;
            leftover_reg  <= '0;
            last_time_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dur_reg       <= dur_next;
            fcnt_reg      <= fcnt_next;
            loop_reg      <= loop_next;
            thr_reg       <= thr_next;
            loaded_reg    <= loaded_next;
            paused_reg    <= paused_next;
            finished_reg  <= finished_next;
            cur_frame_reg <= cur_frame_next;
            loops_reg     <= loops_next;
            leftover_reg  <= leftover_next;
            last_time_reg <= last_time_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        kind_reg       <= kind_next;
        now_reg        <= now_next;
        start_reg      <= start_next;
        prev_frame_reg <= prev_frame_next;
        delta_reg      <= delta_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    `AFS_ASSERT_SAME(a_div_done_in_wait, aclk, aresetn, div_rsp.done, state_reg == ST_DIV1 || state_reg == ST_DIV2, "divider finished outside a wait state")
    `AFS_ASSERT_NEXT(a_accept_to_exec, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_EXEC, "accepted beat did not start execution")
    `AFS_ASSERT_SAME(a_finished_loaded, aclk, aresetn, finished_reg, loaded_reg, "finished flag without a loaded clip")
    `AFS_ASSERT_NEXT(a_leftover_below_dur, aclk, aresetn, state_reg == ST_DIV1 && div_rsp.done, leftover_reg < LEFT_W'(dur_eff), "leftover not below frame duration")

endmodule

// ===== rtl/afs_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on afs_pkg for widths and the request/response structs.
module afs_div import afs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  afs_div_req_t req,
    output afs_div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // dividend shifts out the top while quotient bits shift in below
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== verif/frame_sequence_checker.sv =====
`timescale 1ns / 1ps
// Passive checker for the animation frame sequencer: tracks config writes, predicts
// one status beat per accepted event beat and compares results in order.
// Depends on afs_pkg.
module frame_sequence_checker import afs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // now_ms[47:0], start_frame[63:48]
    input  logic [KIND_W-1:0]     s_tuser,   // kind[2:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // frame_changed[0], frame_index[16:1], loop_count[48:17], finished[49],
    // paused[50], zero fill[55:51]
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    outstanding
);

    localparam int LOOP_LO    = FRAME_BITS + 1;
    localparam int FINISH_BIT = FRAME_BITS + LOOP_W + 1;
    localparam int PAUSE_BIT  = FINISH_BIT + 1;
    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic                  changed;
        logic [FRAME_BITS-1:0] frame;
        logic [LOOP_W-1:0]     loops;
        logic                  finished;
        logic                  paused;
    } frame_report_t;

    frame_report_t expected_frames[$];

    logic [DUR_W-1:0]      cfg_duration;
    logic [FCNT_W-1:0]     cfg_count;
    logic                  cfg_loop;
    logic [THR_W-1:0]      cfg_threshold;

    logic                  clip_loaded;
    logic                  clip_paused;
    logic                  clip_finished;
    logic [FRAME_BITS-1:0] cur_frame;
    logic [LOOP_W-1:0]     loops_done;
    logic [LEFT_W-1:0]     leftover_ms;
    logic [TIME_BITS-1:0]  mark_ms;

    int errors = 0;
    assign error_count = errors;

    function automatic logic [16:0] frame_ms();
        return (cfg_duration == 0) ? 17'd1 : {1'b0, cfg_duration};
    endfunction

    // count register is as wide as the frame index, so the 2^FRAME_BITS cap never bites
    function automatic logic [16:0] frame_total();
        return (cfg_count == 0) ? 17'd1 : {1'b0, cfg_count};
    endfunction

    function automatic void restart_clip(input logic [FRAME_BITS-1:0] start,
                                         input logic [TIME_BITS-1:0] now);
        logic [16:0] last;
        last = frame_total() - 17'd1;
        clip_loaded   = 1'b1;
        cur_frame     = ({1'b0, start} > last) ? last[FRAME_BITS-1:0] : start;
        loops_done    = '0;
        leftover_ms   = '0;
        clip_finished = 1'b0;
        mark_ms       = now;
    endfunction

    function automatic frame_report_t advance_clip(input logic [KIND_W-1:0] kind,
                                                   input logic [TIME_BITS-1:0] now,
                                                   input logic [FRAME_BITS-1:0] start);
        logic [TIME_BITS-1:0]  delta;
        logic [63:0]           steps;
        logic [63:0]           absolute;
        logic [FRAME_BITS-1:0] prev;
        logic                  moved;
        frame_report_t         rep;
        moved = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (clip_loaded && !clip_paused && !clip_finished) begin
                    if (now <= mark_ms) begin
                        mark_ms = now;
                    end else begin
                        delta   = now - mark_ms;
                        mark_ms = now;
                        if (delta > cfg_threshold)
                            delta = TIME_BITS'(frame_ms());
                        leftover_ms = leftover_ms + delta[LEFT_W-1:0];
                        if (leftover_ms >= frame_ms()) begin
                            steps       = 64'(leftover_ms) / 64'(frame_ms());
                            leftover_ms = leftover_ms % frame_ms();
                            prev        = cur_frame;
                            absolute    = cur_frame + steps;
                            if (cfg_loop) begin
                                loops_done = loops_done + LOOP_W'(absolute / frame_total());
                                cur_frame  = FRAME_BITS'(absolute % frame_total());
                            end else if (absolute >= frame_total()) begin
                                cur_frame     = FRAME_BITS'(frame_total() - 17'd1);
                                clip_finished = 1'b1;
                            end else begin
                                cur_frame = absolute[FRAME_BITS-1:0];
                            end
                            moved = (cur_frame != prev);
                        end
                    end
                end
            end
            KIND_PLAY: begin
                if (!clip_loaded)
                    restart_clip('0, now);
            end
            KIND_RESTART: restart_clip(start, now);
            KIND_PAUSE:   clip_paused = 1'b1;
            KIND_RESUME: begin
                if (clip_paused) begin
                    clip_paused = 1'b0;
                    mark_ms     = now;
                    leftover_ms = '0;
                end
            end
            default: ;
        endcase
        rep.changed  = moved;
        rep.frame    = cur_frame;
        rep.loops    = loops_done;
        rep.finished = clip_finished;
        rep.paused   = clip_paused;
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (errors < MAX_REPORTS)
                $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        frame_report_t want;
        if (!aresetn) begin
            cfg_duration  = RST_DURATION;
            cfg_count     = RST_COUNT;
            cfg_loop      = RST_LOOP_MODE;
            cfg_threshold = RST_THRESHOLD;
            clip_loaded   = 1'b0;
            clip_paused   = 1'b0;
            clip_finished = 1'b0;
            cur_frame     = '0;
            loops_done    = '0;
            leftover_ms   = '0;
            mark_ms       = '0;
            expected_frames.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DURATION:  cfg_duration  = cfg_data[DUR_W-1:0];
                    REG_COUNT:     cfg_count     = cfg_data[FCNT_W-1:0];
                    REG_LOOP_MODE: cfg_loop      = cfg_data[0];
                    REG_THRESHOLD: cfg_threshold = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            // check the result beat before queueing the event of this same edge
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    if (errors < MAX_REPORTS)
                        $display("[%0t] unexpected result beat: expected none, got 0x%0h",
                                 $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("frame_changed", want.changed, m_tdata[0]);
                    check_field("frame_index", want.frame, m_tdata[FRAME_BITS:1]);
                    check_field("loop_count", want.loops, m_tdata[FINISH_BIT-1:LOOP_LO]);
                    check_field("finished", want.finished, m_tdata[FINISH_BIT]);
                    check_field("paused", want.paused, m_tdata[PAUSE_BIT]);
                    check_field("zero fill", 0, m_tdata[OUT_DATA_W-1:OUT_RAW_W]);
                end
            end
            if (s_tvalid && s_tready)
                expected_frames.push_back(advance_clip(s_tuser, s_tdata[TIME_BITS-1:0],
                    s_tdata[TIME_BITS+FRAME_BITS-1:TIME_BITS]));
        end
        outstanding <= expected_frames.size();
    end

endmodule

// ===== verif/tb_animation_frame_sequencer.sv =====
`timescale 1ns / 1ps
// Top of the animation frame sequencer testbench: clock, reset, event and config
// stimulus, receiver back-pressure and the verdict. Depends on afs_pkg, the RTL
// and frame_sequence_checker.
module tb_animation_frame_sequencer;
    import afs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = KIND_RESUME + 1'b1;
    localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = '1;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_EVENTS  = 101;
    localparam int TAIL_CYCLES   = 64;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_LONG_HOLD} rx_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = KIND_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_DURATION;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int error_count;
    int outstanding;

    int burst_left = 3;
    logic [TIME_BITS-1:0] clock_ms = '0;

    rx_mode_t rx_mode   = RX_ALWAYS;
    int       rx_left   = 0;
    int       rx_period = 3;
    int       rx_cyc    = 0;

    animation_frame_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_sequence_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver back-pressure: a new random pattern is drawn whenever rx_left runs out
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode   = rx_mode_t'($urandom_range(0, 3));
            rx_left   = $urandom_range(64, 256);
            rx_period = $urandom_range(2, 9);
        end else begin
            rx_left--;
        end
        rx_cyc++;
        case (rx_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_tready <= (rx_cyc % rx_period) != 0;
            default:     m_tready <= (rx_cyc % 40) >= 20;
        endcase
    end

    task automatic send_event(input logic [KIND_W-1:0] kind,
                              input logic [TIME_BITS-1:0] now,
                              input logic [FRAME_BITS-1:0] start);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {start, now};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 10);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic reconfigure(input logic [DUR_W-1:0] dur, input logic [FCNT_W-1:0] cnt,
                               input logic loop_on, input logic [THR_W-1:0] thr);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] vals [4];
        idx  = '{REG_DURATION, REG_COUNT, REG_LOOP_MODE, REG_THRESHOLD};
        vals = '{CFG_DATA_W'(dur), CFG_DATA_W'(cnt), CFG_DATA_W'(loop_on), CFG_DATA_W'(thr)};
        wait_idle();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // default config: 100 ms, one frame, loop, 2000 ms threshold
        send_event(KIND_TICK, 48'd500, 16'd0);       // nothing loaded
        send_event(KIND_PAUSE, 48'd0, 16'd0);        // pause without a clip
        send_event(KIND_RESUME, 48'd600, 16'd0);
        send_event(KIND_RESUME, 48'd650, 16'd0);     // not paused
        send_event(KIND_PLAY, 48'd1000, 16'd0);
        send_event(KIND_PLAY, 48'd5000, 16'd0);      // already loaded
        send_event(KIND_TICK, 48'd1250, 16'd0);

        reconfigure(16'd10, 16'd4, 1'b1, 24'd1000);
        send_event(KIND_RESTART, 48'd2000, 16'hFFFF); // clamps to last frame
        send_event(KIND_TICK, 48'd2005, 16'd0);
        send_event(KIND_TICK, 48'd2015, 16'd0);
        send_event(KIND_TICK, 48'd2015, 16'd0);      // time stands still
        send_event(KIND_TICK, 48'd1990, 16'd0);      // time goes back
        send_event(KIND_TICK, 48'd2030, 16'd0);      // full loop, same frame
        send_event(KIND_TICK, '1, 16'd0);            // jump past threshold
        send_event(KIND_PAUSE, 48'd0, 16'd0);
        send_event(KIND_RESTART, 48'd3000, 16'd2);   // pause survives restart
        send_event(KIND_TICK, 48'd3100, 16'd0);
        send_event(KIND_RESUME, 48'd3200, 16'd0);
        send_event(KIND_TICK, 48'd3210, 16'd0);
        send_event(KIND_FIRST_UNUSED, '1, 16'hFFFF);
        send_event(KIND_LAST_UNUSED, 48'h5555_5555_5555, 16'h5555);

        reconfigure(16'd0, 16'd0, 1'b0, 24'hFFFFFF);
        send_event(KIND_RESTART, 48'd0, 16'd0);
        send_event(KIND_TICK, 48'd1, 16'd0);         // once mode ends at once
        send_event(KIND_TICK, 48'd2, 16'd0);

        // shrink the clip under a loaded frame, once and loop mode
        reconfigure(16'd5, 16'd8, 1'b0, 24'd100);
        send_event(KIND_RESTART, 48'd100, 16'd7);
        reconfigure(16'd5, 16'd3, 1'b0, 24'd100);
        send_event(KIND_TICK, 48'd105, 16'd0);
        reconfigure(16'd5, 16'd8, 1'b1, 24'd100);
        send_event(KIND_RESTART, 48'd200, 16'd7);
        reconfigure(16'd5, 16'd3, 1'b1, 24'd100);
        send_event(KIND_TICK, 48'd205, 16'd0);
    endtask

    task automatic run_random_phase(input int phase, input int n_events);
        logic [DUR_W-1:0]      dur;
        logic [FCNT_W-1:0]     cnt;
        logic [THR_W-1:0]      thr;
        logic [FRAME_BITS-1:0] start;
        int dur_e;
        int cnt_e;
        int pick;
        int sel;
        sel = (phase < 6) ? phase : $urandom_range(0, 5);
        case (sel)
            0: begin dur = '1; cnt = '1; end
            1: begin dur = '0; cnt = DUR_W'($urandom_range(0, 3)); end
            2: begin dur = DUR_W'($urandom_range(1, 20)); cnt = DUR_W'($urandom_range(2, 12)); end
            3: begin dur = DUR_W'($urandom_range(1, 300)); cnt = FCNT_W'($urandom); end
            4: begin dur = DUR_W'($urandom); cnt = FCNT_W'($urandom_range(1, 64)); end
            default: begin dur = DUR_W'($urandom_range(1, 8)); cnt = 16'd1; end
        endcase
        dur_e = (dur == 0) ? 1 : dur;
        cnt_e = (cnt == 0) ? 1 : cnt;
        case ($urandom_range(0, 5))
            0:       thr = '0;
            1:       thr = '1;
            default: thr = THR_W'(dur_e + $urandom_range(0, 8 * dur_e + 200));
        endcase
        reconfigure(dur, cnt, 1'($urandom_range(0, 1)), thr);

        case ($urandom_range(0, 3))
            0: clock_ms = {16'hFFFF, $urandom} - $urandom_range(0, 100000);
            1: clock_ms = TIME_BITS'({$urandom, $urandom});
            default: ;
        endcase
        // most phases start a fresh clip; the rest keep playing under the new config
        if ($urandom_range(0, 3) != 0)
            send_event(KIND_RESTART, clock_ms, FRAME_BITS'($urandom_range(0, cnt_e - 1)));

        for (int i = 0; i < n_events; i++) begin
            pick  = $urandom_range(0, 99);
            start = ($urandom_range(0, 1) == 0) ? FRAME_BITS'($urandom)
                                               : FRAME_BITS'($urandom_range(0, cnt_e - 1));
            if (pick < 72) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    clock_ms = clock_ms + $urandom_range(0, 3 * dur_e);
                else if (sel < 80)
                    clock_ms = clock_ms - $urandom_range(0, 50);
                else if (sel < 90)
                    clock_ms = clock_ms + thr + $urandom_range(1, 5000);
                else
                    clock_ms = TIME_BITS'({$urandom, $urandom});
                send_event(KIND_TICK, clock_ms, start);
            end else if (pick < 76) begin
                send_event(KIND_PAUSE, TIME_BITS'({$urandom, $urandom}), start);
            end else if (pick < 85) begin
                clock_ms = clock_ms + $urandom_range(0, 4 * dur_e);
                send_event(KIND_RESUME, clock_ms, start);
            end else if (pick < 92) begin
                send_event(KIND_RESTART, clock_ms, start);
            end else if (pick < 95) begin
                send_event(KIND_PLAY, clock_ms, start);
            end else if (pick < 98) begin
                send_event(KIND_W'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED)),
                           TIME_BITS'({$urandom, $urandom}), FRAME_BITS'($urandom));
            end else begin
                send_event(KIND_TICK, TIME_BITS'({$urandom, $urandom}), start);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(p, PHASE_EVENTS);
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/afs_pkg.sv
rtl/afs_div.sv
rtl/animation_frame_sequencer.sv
verif/frame_sequence_checker.sv
verif/tb_animation_frame_sequencer.sv
